/* src/ihexd_pkg.sv */
// Shared types, character codes and helpers for the hex record decoder.
package ihexd_pkg;

	localparam logic [7:0] CH_CR    = 8'h0D;
	localparam logic [7:0] CH_LF    = 8'h0A;
	localparam logic [7:0] CH_COLON = 8'h3A;
	localparam logic [7:0] CH_0     = 8'h30;
	localparam logic [7:0] CH_9     = 8'h39;
	localparam logic [7:0] CH_A     = 8'h41;
	localparam logic [7:0] CH_F     = 8'h46;

	// fixed part of a record after the colon: length, address, type, checksum digits
	localparam logic [9:0] REC_OVERHEAD = 10'd10;

	localparam logic [1:0] PH_FIRST = 2'd0;
	localparam logic [1:0] PH_LINE  = 2'd1;
	localparam logic [1:0] PH_GAP   = 2'd2;

	typedef struct packed {
		logic [1:0] phase;
		logic [9:0] line_offset;
		logic [7:0] record_length;
		logic [3:0] high_nibble;
		logic       error_seen;
	} state_t;

	typedef struct packed {
		logic       byte_valid;
		logic [7:0] data_byte;
		logic       error;
		logic       done_res;
	} result_t;

	localparam state_t STATE_RESET = '{
		phase:         PH_FIRST,
		line_offset:   10'd0,
		record_length: 8'd0,
		high_nibble:   4'd0,
		error_seen:    1'b0
	};

	// uppercase hex digit: bit 4 = valid, bits 3:0 = value
	function automatic logic [4:0] hex_digit(input logic [7:0] c);
		logic [7:0] d;
		begin
			d = 8'd0;
			if (c >= CH_A && c <= CH_F) begin
				d = c - CH_A + 8'd10;
				hex_digit = {1'b1, d[3:0]};
			end else if (c >= CH_0 && c <= CH_9) begin
				d = c - CH_0;
				hex_digit = {1'b1, d[3:0]};
			end else begin
				hex_digit = 5'd0;
			end
		end
	endfunction

	// characters expected after the colon for a given record length
	function automatic logic [9:0] line_limit(input logic [7:0] len);
		line_limit = {1'b0, len, 1'b0} + REC_OVERHEAD;
	endfunction

endpackage

/* src/ihexd_step.sv */
// Next-state and result logic for one character.
module ihexd_step (
	input  ihexd_pkg::state_t  cur,
	input  logic [7:0]         char_code,
	input  logic               last,
	output ihexd_pkg::state_t  nxt,
	output ihexd_pkg::result_t res,
	output logic               emit
);

	logic       eol;
	logic       colon;
	logic [4:0] dig;
	logic       ok;
	logic [9:0] limit_cur;
	logic [9:0] limit_nxt;
	logic [9:0] n;
	logic [9:0] data_end;
	logic       got;
	logic [7:0] byte_val;
	logic       err_now;

	assign eol       = (char_code == ihexd_pkg::CH_CR) || (char_code == ihexd_pkg::CH_LF);
	assign colon     = (char_code == ihexd_pkg::CH_COLON);
	assign dig       = ihexd_pkg::hex_digit(char_code);
	assign ok        = dig[4];
	assign limit_cur = ihexd_pkg::line_limit(cur.record_length);
	assign n         = cur.line_offset + 10'd1;
	assign data_end  = limit_cur - 10'd2;

	always_comb begin
		ihexd_pkg::state_t s;
		s        = cur;
		got      = 1'b0;
		byte_val = 8'd0;
		if (!cur.error_seen) begin
			if (cur.phase == ihexd_pkg::PH_LINE) begin
				if (eol) begin
					if (cur.line_offset != limit_cur)
						s.error_seen = 1'b1;
					s.phase = ihexd_pkg::PH_GAP;
				end else if (n > limit_cur) begin
					s.error_seen = 1'b1;
				end else begin
					s.line_offset = n;
					if (n == 10'd1) begin
						if (ok)
							s.high_nibble = dig[3:0];
						else
							s.error_seen = 1'b1;
					end else if (n == 10'd2) begin
						if (ok)
							s.record_length = {cur.high_nibble, dig[3:0]};
						else
							s.error_seen = 1'b1;
					end else if (n >= 10'd9 && n <= data_end) begin
						if (!ok) begin
							s.error_seen = 1'b1;
						end else if (n[0]) begin
							s.high_nibble = dig[3:0];
						end else begin
							got      = 1'b1;
							byte_val = {cur.high_nibble, dig[3:0]};
						end
					end
				end
			end else if (cur.phase == ihexd_pkg::PH_GAP && eol) begin
				s = cur;
			end else if (colon) begin
				s.phase         = ihexd_pkg::PH_LINE;
				s.line_offset   = 10'd0;
				s.record_length = 8'd0;
				s.high_nibble   = 4'd0;
			end else begin
				// bad line start, or line break before the first line
				s.error_seen = 1'b1;
			end
		end
		// stream ends inside a line that is short
		if (last && !s.error_seen && s.phase == ihexd_pkg::PH_LINE
			&& s.line_offset != limit_nxt)
			s.error_seen = 1'b1;
		err_now = s.error_seen;
		nxt     = last ? ihexd_pkg::STATE_RESET : s;
	end

	assign limit_nxt = ihexd_pkg::line_limit(
		(!cur.error_seen && cur.phase == ihexd_pkg::PH_LINE && !eol && n == 10'd2 && ok)
		? {cur.high_nibble, dig[3:0]} : cur.record_length);

	assign res.byte_valid = got && !err_now;
	assign res.data_byte  = (got && !err_now) ? byte_val : 8'd0;
	assign res.error      = err_now;
	assign res.done_res   = last;
	assign emit = (got && !err_now) || (err_now && !cur.error_seen) || last;

endmodule

/* src/ihexd_out_reg.sv */
// Result register with valid/ready handshake toward the receiver.
module ihexd_out_reg (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               load,
	input  ihexd_pkg::result_t res_in,
	output logic               space,
	output logic               out_valid,
	input  logic               out_ready,
	output ihexd_pkg::result_t res_out
);

	logic               valid_q;
	ihexd_pkg::result_t res_q;

	// room for a new result when empty or when the held one leaves this cycle
	assign space = !valid_q || out_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (space) begin
			valid_q <= load;
		end
	end

	always_ff @(posedge clk) begin
		if (space && load) begin
			res_q <= res_in;
		end
	end

	assign out_valid = valid_q;
	assign res_out   = res_q;

endmodule

/* src/intel_hex_record_decoder_top.sv */
// Top level of the hex record decoder: state register, step logic, result register.
//
// Usage:
//   Input channel (in_valid/in_ready, char_code, last) takes one character of
//   hex text per transfer. last marks the final character of a stream and also
//   closes the current line.
//   Output channel (out_valid/out_ready) carries byte_valid, data_byte, error
//   and done_res. A result is produced for every decoded data byte, for the
//   character that first raises the error flag, and for the last character.
//   Other characters are consumed without a result.
// Output: a result is registered and appears in the cycle after the character's
//   transfer. Throughput: one character per cycle while the receiver keeps up;
//   the decode state update is a single short combinational pass.
// Stall: the result register holds while out_ready is low; in_ready drops only
//   while a result is held and out_ready is low, so a character is taken in the
//   same cycle as the held result leaves.
// Reset: arst_n clears the decode state to "before first line" and empties the
//   result register. After the result for last, the state returns to its reset
//   values and the next character starts a new stream.
// error is sticky within a stream; once set, all bytes of that stream are void.
module intel_hex_record_decoder_top (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	output logic       in_ready,
	input  logic [7:0] char_code,
	input  logic       last,
	output logic       out_valid,
	input  logic       out_ready,
	output logic       byte_valid,
	output logic [7:0] data_byte,
	output logic       error,
	output logic       done_res
);

	ihexd_pkg::state_t  state_q;
	ihexd_pkg::state_t  state_nxt;
	ihexd_pkg::result_t step_res;
	ihexd_pkg::result_t out_res;
	logic               step_emit;
	logic               space;
	logic               in_xfer;

	assign in_ready = space;
	assign in_xfer  = in_valid && in_ready;

	// decode state advances on every input transfer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ihexd_pkg::STATE_RESET;
		end else if (in_xfer) begin
			state_q <= state_nxt;
		end
	end

	ihexd_step u_step (
		.cur       (state_q),
		.char_code (char_code),
		.last      (last),
		.nxt       (state_nxt),
		.res       (step_res),
		.emit      (step_emit)
	);

	ihexd_out_reg u_out (
		.clk       (clk),
		.arst_n    (arst_n),
		.load      (in_xfer && step_emit),
		.res_in    (step_res),
		.space     (space),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.res_out   (out_res)
	);

	assign byte_valid = out_res.byte_valid;
	assign data_byte  = out_res.data_byte;
	assign error      = out_res.error;
	assign done_res   = out_res.done_res;

endmodule

/* src/ihexd_checker.sv */
// Port-level checks for the hex record decoder, bound to the top level.
module ihexd_checker (
	input logic       clk,
	input logic       arst_n,
	input logic       in_ready,
	input logic       out_valid,
	input logic       out_ready,
	input logic       byte_valid,
	input logic [7:0] data_byte,
	input logic       error,
	input logic       done_res
);

	logic err_seen_q;

	// error shown on an earlier result of the current stream
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			err_seen_q <= 1'b0;
		end else if (out_valid && out_ready) begin
			err_seen_q <= error && !done_res;
		end
	end

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(data_byte) && $stable(byte_valid))
		else $error("result changed while stalled");

	a_byte_no_err: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && byte_valid |-> !error)
		else $error("byte reported together with error");

	a_zero_byte: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !byte_valid |-> data_byte == 8'd0)
		else $error("data_byte nonzero without byte_valid");

	a_err_sticky: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && err_seen_q |-> error && !byte_valid)
		else $error("error flag dropped within a stream");

	a_ready_free: assert property (@(posedge clk) disable iff (!arst_n)
		!out_valid |-> in_ready)
		else $error("input stalled with empty result register");

endmodule

bind intel_hex_record_decoder_top ihexd_checker u_ihexd_checker (
	.clk        (clk),
	.arst_n     (arst_n),
	.in_ready   (in_ready),
	.out_valid  (out_valid),
	.out_ready  (out_ready),
	.byte_valid (byte_valid),
	.data_byte  (data_byte),
	.error      (error),
	.done_res   (done_res)
);
